/* sv/psd_pkg.sv */
// Shared types and constants for the pair sum detector.
`default_nettype none

package psd_pkg;

    localparam int EPOCH_BITS = 8;
    localparam int TARGET_W   = 17;
    localparam int VAL_W      = 16;

    localparam logic [EPOCH_BITS-1:0] EPOCH_FREE  = '0;
    localparam logic [EPOCH_BITS-1:0] EPOCH_FIRST = EPOCH_BITS'(1);
    localparam logic [EPOCH_BITS-1:0] EPOCH_LAST  = '1;

    typedef enum logic {
        S_CLEAR,
        S_RUN
    } t_state;

    typedef struct packed {
        logic                  busy;
        logic [EPOCH_BITS-1:0] epoch;
    } t_clr_stat;

endpackage

`default_nettype wire

/* sv/psd_ram.sv */
// Generic simple dual-port RAM with registered read and read enable.
`default_nettype none

module psd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

/* sv/psd_clear.sv */
// List epoch counter and bitmap clearing sequencer.
`default_nettype none

module psd_clear #(
    parameter int ADDR_W = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_list_done,
    output psd_pkg::t_clr_stat     o_stat,
    output logic      [ADDR_W-1:0] o_clr_addr
);

    import psd_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [ADDR_W-1:0]     r_addr;
    logic [ADDR_W-1:0]     n_addr;
    logic [EPOCH_BITS-1:0] r_epoch;
    logic [EPOCH_BITS-1:0] n_epoch;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_addr == '1) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (i_list_done && r_epoch == EPOCH_LAST) begin
                    n_state = S_CLEAR;
                end
            end
            default: n_state = S_CLEAR;
        endcase
    end

    // counters
    always_comb begin
        n_addr  = r_addr;
        n_epoch = r_epoch;
        case (r_state)
            S_CLEAR: begin
                n_addr = r_addr + ADDR_W'(1);
            end
            S_RUN: begin
                n_addr = '0;
                if (i_list_done) begin
                    n_epoch = (r_epoch == EPOCH_LAST) ? EPOCH_FIRST
                                                      : r_epoch + EPOCH_BITS'(1);
                end
            end
            default: begin
                n_addr  = '0;
                n_epoch = EPOCH_FIRST;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_stat.busy  = 1'b0;
        o_stat.epoch = r_epoch;
        o_clr_addr   = r_addr;
        case (r_state)
            S_CLEAR: o_stat.busy = 1'b1;
            S_RUN:   o_stat.busy = 1'b0;
            default: o_stat.busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_addr  <= '0;
            r_epoch <= EPOCH_FIRST;
        end else begin
            r_state <= n_state;
            r_addr  <= n_addr;
            r_epoch <= n_epoch;
        end
    end

    a_epoch_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_epoch != EPOCH_FREE)
        else $error("epoch reached the free tag");

    a_done_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_list_done |-> r_state == S_RUN)
        else $error("list end during clearing pass");

endmodule

`default_nettype wire

/* sv/pair_sum_detector.sv */
// Top level of the streaming pair sum detector.
`default_nettype none

// Takes one value per cycle while o_in_stall is low and returns one result per value from
// the output register; a request passes stage one (RAM read, s1 registers) before it. The
// bitmap lives in one RAM of 2^VALUE_BITS tag entries; each list gets its own tag, so the
// end of a list costs nothing. The read port looks up the complement and the write port
// marks the value in the same cycle, so the rate is one item per cycle when not stalled.
// After reset, and after every 255th list end, a clearing pass rewrites the whole RAM with
// the free tag while the input is stalled; configuration writes are taken at any time.
module pair_sum_detector #(
    parameter int VALUE_BITS = 16
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire logic [psd_pkg::VAL_W-1:0]      i_item_value,
    input  wire logic                           i_last_item,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output logic                                o_pair_found,
    output logic      [psd_pkg::VAL_W-1:0]      o_partner_value,
    output logic      [psd_pkg::VAL_W-1:0]      o_echo_value,
    output logic                                o_list_end,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [psd_pkg::TARGET_W-1:0]   i_cfg_data
);

    import psd_pkg::*;

    localparam int DEPTH = 1 << VALUE_BITS;
    localparam int XW    = (VALUE_BITS > TARGET_W) ? VALUE_BITS + 1 : TARGET_W + 1;
    localparam logic [XW-1:0] VMAX = XW'(DEPTH - 1);

    t_clr_stat               clr_stat;
    logic [VALUE_BITS-1:0]   clr_addr;

    logic [TARGET_W-1:0]     r_target;

    logic                    accept;
    logic                    out_free;
    logic                    s1_adv;
    logic [XW-1:0]           val_x;
    logic [XW-1:0]           tgt_x;
    logic [XW-1:0]           diff;
    logic                    in_range;
    logic                    comp_ok;

    logic                    ram_we;
    logic [VALUE_BITS-1:0]   ram_waddr;
    logic [EPOCH_BITS-1:0]   ram_wdata;
    logic [EPOCH_BITS-1:0]   ram_rdata;

    logic                    r_s1_valid;
    logic                    r_s1_chk;
    logic [EPOCH_BITS-1:0]   r_s1_epoch;
    logic [VAL_W-1:0]        r_s1_partner;
    logic [VAL_W-1:0]        r_s1_value;
    logic                    r_s1_last;
    logic                    s1_found;

    assign o_cfg_ready = 1'b1;

    assign out_free   = !o_out_valid || !i_out_stall;
    assign s1_adv     = !r_s1_valid || out_free;
    assign o_in_stall = clr_stat.busy || !s1_adv;
    assign accept     = i_in_valid && !o_in_stall;

    assign val_x    = XW'(i_item_value);
    assign tgt_x    = XW'(r_target);
    assign diff     = tgt_x - val_x;
    assign in_range = val_x <= VMAX;
    assign comp_ok  = in_range && (tgt_x >= val_x) && (diff <= VMAX);

    // clearing pass writes the free tag; otherwise mark the value with the list tag
    always_comb begin
        if (clr_stat.busy) begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr;
            ram_wdata = EPOCH_FREE;
        end else begin
            ram_we    = accept && in_range;
            ram_waddr = val_x[VALUE_BITS-1:0];
            ram_wdata = clr_stat.epoch;
        end
    end

    psd_clear #(
        .ADDR_W (VALUE_BITS)
    ) u_clear (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_list_done (accept && i_last_item),
        .o_stat      (clr_stat),
        .o_clr_addr  (clr_addr)
    );

    // read-first: a lookup never sees the mark written by the same request
    psd_ram #(
        .WIDTH (EPOCH_BITS),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (accept),
        .i_raddr (diff[VALUE_BITS-1:0]),
        .o_rdata (ram_rdata)
    );

    assign s1_found = r_s1_chk && (ram_rdata == r_s1_epoch);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_target <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_adv) begin
            r_s1_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_chk     <= comp_ok;
            r_s1_epoch   <= clr_stat.epoch;
            r_s1_partner <= diff[VAL_W-1:0];
            r_s1_value   <= i_item_value;
            r_s1_last    <= i_last_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (out_free) begin
            o_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && r_s1_valid) begin
            o_pair_found    <= s1_found;
            o_partner_value <= s1_found ? r_s1_partner : '0;
            o_echo_value    <= r_s1_value;
            o_list_end      <= r_s1_last;
        end
    end

    a_clear_writes_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_stat.busy |-> (ram_we && ram_wdata == EPOCH_FREE))
        else $error("clearing pass wrote a live tag");

    a_accept_fills_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted request lost before stage one");

    a_pair_sums: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_pair_found) |->
            ((VALUE_BITS > VAL_W) ||
             (TARGET_W'(o_partner_value) + TARGET_W'(o_echo_value) == r_target)))
        else $error("reported pair does not reach the target");

    a_no_pair_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_pair_found) |-> (o_partner_value == '0))
        else $error("partner value set without a pair");

endmodule

`default_nettype wire
